// ----- rtl/ced_pkg.sv -----
// Shared types and constants for the coin eject delay scheduler.
// Holds time arithmetic, coin and result codes, cell opcodes and register map.
// No dependencies.
package ced_pkg;

  // Signed remaining time of one queued ejection
  typedef logic signed [13:0] time_t;

  localparam time_t TIME_MIN = -14'sd8192;

  // Ejection delays per coin type
  localparam time_t DELAY_YUAN   = 14'sd3000;
  localparam time_t DELAY_JIAO   = 14'sd4000;
  localparam time_t DELAY_WUJIAO = 14'sd5000;
  localparam time_t DELAY_FALSE  = 14'sd6000;

  // Coin type codes
  localparam logic [1:0] COIN_JIAO   = 2'd0;
  localparam logic [1:0] COIN_WUJIAO = 2'd1;
  localparam logic [1:0] COIN_YUAN   = 2'd2;
  localparam logic [1:0] COIN_FALSE  = 2'd3;

  // Result kind codes
  localparam logic [1:0] KIND_QUEUED = 2'd0;
  localparam logic [1:0] KIND_EJECT  = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;
  localparam logic [1:0] KIND_FULL   = 2'd3;

  // Most ejections reported by one tick
  localparam logic [4:0] EJECT_MAX = 5'd16;

  // Configuration register indexes
  localparam logic [2:0] REG_TICK        = 3'd0;
  localparam logic [2:0] REG_PULSE       = 3'd1;
  localparam logic [2:0] REG_BIG_LOW     = 3'd2;
  localparam logic [2:0] REG_BIG_HIGH    = 3'd3;
  localparam logic [2:0] REG_MID_LOW     = 3'd4;
  localparam logic [2:0] REG_MID_HIGH    = 3'd5;
  localparam logic [2:0] REG_COLOR_LIMIT = 3'd6;

  // Cell opcodes
  localparam logic [1:0] OP_HOLD  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_KEEP  = 2'd2;
  localparam logic [1:0] OP_EJECT = 2'd3;

  // Control broadcast to every cell of the queue
  typedef struct packed {
    logic [1:0] op;
    time_t      new_time;
    logic [1:0] new_type;
    logic [9:0] pulse;
  } cell_ctl_t;

  // Subtract an unsigned amount, clamping at the time floor
  function automatic time_t sat_sub(time_t v, logic [9:0] amt);
    logic signed [14:0] d;
    d = $signed({v[13], v}) - $signed({5'b0, amt});
    if (d < $signed({TIME_MIN[13], TIME_MIN})) begin
      return TIME_MIN;
    end
    return d[13:0];
  endfunction

endpackage

// ----- rtl/ced_cell.sv -----
// One queue slot of the coin eject delay scheduler: remaining time and coin type.
// Loads, ticks, takes pulses and shifts in its upper neighbor on removal.
// Depends on ced_pkg.
module ced_cell #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic               clk,
  input  ced_pkg::cell_ctl_t ctl,
  input  logic [CW-1:0]      ptr,
  input  ced_pkg::time_t     nxt_time,
  input  logic [1:0]         nxt_type,
  output ced_pkg::time_t     time_q,
  output logic [1:0]         type_q
);
  import ced_pkg::*;

  time_t      time_r;
  logic [1:0] type_r;
  logic       here;
  logic       above;

  assign here  = (ptr == CW'(IDX));
  assign above = (ptr <= CW'(IDX));

  // Apply the broadcast operation to this slot
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        if (here) begin
          time_r <= ctl.new_time;
          type_r <= ctl.new_type;
        end
      end
      OP_KEEP: begin
        if (here) begin
          time_r <= ctl.new_time;
        end
      end
      OP_EJECT: begin
        if (above) begin
          time_r <= sat_sub(nxt_time, ctl.pulse);
          type_r <= nxt_type;
        end else begin
          time_r <= sat_sub(time_r, ctl.pulse);
        end
      end
      default: begin
      end
    endcase
  end

  assign time_q = time_r;
  assign type_q = type_r;

endmodule

// ----- rtl/coin_eject_delay_scheduler_core.sv -----
// Coin eject delay scheduler: classifies detected coins and times their ejection.
// Depends on ced_pkg and ced_cell (one cell per queue slot).
//
// Input channel (in_valid/in_ready): in_action 1 is a coin detection carrying
// in_diameter and in_color_diff; in_action 0 is a time tick.
// Result channel (out_valid/out_ready): out_kind, out_coin_type, out_type_count
// and out_last, which marks the final result of a request.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_index at once.
//
// A detection's single result shows the cycle after it is accepted. A tick walks
// the queue one slot per cycle through the row of cells unless stalled, with one
// result per ejection; a removal shifts the upper cells down in the same cycle.
// One request is worked on at a time; in_ready returns once the final result is in
// the output register and that register can take a new one. When the receiver
// stalls, the walk stops at its end, or at an ejection with one already held, until
// the output register frees. Reset empties the queue, clears the coin counters and
// loads the register defaults; slot contents need no clearing.
module coin_eject_delay_scheduler_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [9:0]  in_diameter,
  input  logic [8:0]  in_color_diff,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_coin_type,
  output logic [31:0] out_type_count,
  output logic        out_last,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_wdata
);
  import ced_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  // Configuration registers
  logic [9:0] tick_amount_r, pulse_amount_r;
  logic [9:0] big_low_r, big_high_r, mid_low_r, mid_high_r;
  logic [8:0] color_limit_r;

  // Control state
  logic          state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [4:0]    ej_cnt_r, ej_cnt_nxt;
  logic          pend_valid_r, pend_valid_nxt;
  logic [1:0]    pend_type_r, pend_type_nxt;
  logic [31:0]   type_cnt_r [4];

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_kind_r, out_coin_type_r;
  logic [31:0] out_type_count_r;
  logic        out_last_r;

  // Output load request
  logic        out_load;
  logic [1:0]  o_kind, o_type;
  logic [31:0] o_count;
  logic        o_last;
  logic        out_can_load;

  // Cell row
  cell_ctl_t     cell_ctl;
  logic [CW-1:0] cell_ptr;
  time_t         cell_time [QUEUE_DEPTH];
  logic [1:0]    cell_type [QUEUE_DEPTH];
  time_t         nxt_time  [QUEUE_DEPTH];
  logic [1:0]    nxt_type  [QUEUE_DEPTH];

  // Classification and step datapath
  logic        is_big, is_mid;
  logic [1:0]  det_type;
  time_t       det_delay;
  logic [31:0] det_cnt_cur, det_cnt_inc;
  logic        cnt_wr;
  time_t       sel_time, t_step;
  logic [1:0]  sel_type;
  logic        step_expired;

  assign out_can_load = !out_valid_r || out_ready;
  assign in_ready     = (state_r == ST_IDLE) && out_can_load;

  // Classify a detected coin
  always_comb begin
    is_big = (in_diameter > big_low_r) && (in_diameter < big_high_r);
    is_mid = (in_diameter > mid_low_r) && (in_diameter < mid_high_r);
    if (is_big) begin
      det_type  = COIN_YUAN;
      det_delay = DELAY_YUAN;
    end else if (is_mid && (in_color_diff < color_limit_r)) begin
      det_type  = COIN_JIAO;
      det_delay = DELAY_JIAO;
    end else if (is_mid) begin
      det_type  = COIN_WUJIAO;
      det_delay = DELAY_WUJIAO;
    end else begin
      det_type  = COIN_FALSE;
      det_delay = DELAY_FALSE;
    end
    det_cnt_cur = type_cnt_r[det_type];
    det_cnt_inc = (&det_cnt_cur) ? det_cnt_cur : det_cnt_cur + 32'd1;
  end

  // Tick the slot under the walk pointer
  assign sel_time     = cell_time[ptr_r[IW-1:0]];
  assign sel_type     = cell_type[ptr_r[IW-1:0]];
  assign t_step       = sat_sub(sel_time, tick_amount_r);
  assign step_expired = (t_step[13] || (t_step == '0)) && (ej_cnt_r < EJECT_MAX);

  // Sequence detections and tick walks
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    ej_cnt_nxt     = ej_cnt_r;
    pend_valid_nxt = pend_valid_r;
    pend_type_nxt  = pend_type_r;
    cnt_wr         = 1'b0;
    cell_ctl.op       = OP_HOLD;
    cell_ctl.new_time = t_step;
    cell_ctl.new_type = det_type;
    cell_ctl.pulse    = pulse_amount_r;
    cell_ptr       = ptr_r;
    out_load       = 1'b0;
    o_kind         = KIND_TICK;
    o_type         = COIN_JIAO;
    o_count        = '0;
    o_last         = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_action) begin
            cnt_wr   = 1'b1;
            out_load = 1'b1;
            o_type   = det_type;
            o_count  = det_cnt_inc;
            if (count_r < CW'(QUEUE_DEPTH)) begin
              cell_ctl.op       = OP_LOAD;
              cell_ctl.new_time = det_delay;
              cell_ptr          = count_r;
              count_nxt         = count_r + 1'b1;
              o_kind            = KIND_QUEUED;
            end else begin
              o_kind = KIND_FULL;
            end
          end else begin
            state_nxt      = ST_WALK;
            ptr_nxt        = '0;
            ej_cnt_nxt     = '0;
            pend_valid_nxt = 1'b0;
          end
        end
      end
      ST_WALK: begin
        if (!(ptr_r < count_r)) begin
          // Walk done: hand over the held ejection or a plain tick result
          if (out_can_load) begin
            out_load  = 1'b1;
            state_nxt = ST_IDLE;
            if (pend_valid_r) begin
              o_kind  = KIND_EJECT;
              o_type  = pend_type_r;
              o_count = type_cnt_r[pend_type_r];
            end
          end
        end else if (step_expired) begin
          // Eject: release the held result first, then remove this slot
          if (!pend_valid_r || out_can_load) begin
            if (pend_valid_r) begin
              out_load = 1'b1;
              o_kind   = KIND_EJECT;
              o_type   = pend_type_r;
              o_count  = type_cnt_r[pend_type_r];
              o_last   = 1'b0;
            end
            cell_ctl.op    = OP_EJECT;
            pend_valid_nxt = 1'b1;
            pend_type_nxt  = sel_type;
            count_nxt      = count_r - 1'b1;
            ej_cnt_nxt     = ej_cnt_r + 5'd1;
          end
        end else begin
          cell_ctl.op = OP_KEEP;
          ptr_nxt     = ptr_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Advance the output register
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      ptr_r        <= '0;
      ej_cnt_r     <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        type_cnt_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      ptr_r        <= ptr_nxt;
      ej_cnt_r     <= ej_cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cnt_wr) begin
        type_cnt_r[det_type] <= det_cnt_inc;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_type_r <= pend_type_nxt;
    if (out_load) begin
      out_kind_r       <= o_kind;
      out_coin_type_r  <= o_type;
      out_type_count_r <= o_count;
      out_last_r       <= o_last;
    end
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_amount_r  <= 10'd20;
      pulse_amount_r <= 10'd50;
      big_low_r      <= 10'd180;
      big_high_r     <= 10'd200;
      mid_low_r      <= 10'd145;
      mid_high_r     <= 10'd165;
      color_limit_r  <= 9'd80;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TICK:        tick_amount_r  <= cfg_wdata;
        REG_PULSE:       pulse_amount_r <= cfg_wdata;
        REG_BIG_LOW:     big_low_r      <= cfg_wdata;
        REG_BIG_HIGH:    big_high_r     <= cfg_wdata;
        REG_MID_LOW:     mid_low_r      <= cfg_wdata;
        REG_MID_HIGH:    mid_high_r     <= cfg_wdata;
        REG_COLOR_LIMIT: color_limit_r  <= cfg_wdata[8:0];
        default: begin
        end
      endcase
    end
  end

  // Row of queue cells, each fed by its upper neighbor
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    if (g == QUEUE_DEPTH - 1) begin : g_top
      assign nxt_time[g] = cell_time[g];
      assign nxt_type[g] = cell_type[g];
    end else begin : g_mid
      assign nxt_time[g] = cell_time[g+1];
      assign nxt_type[g] = cell_type[g+1];
    end
    ced_cell #(
      .CW  (CW),
      .IDX (g)
    ) u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .ptr      (cell_ptr),
      .nxt_time (nxt_time[g]),
      .nxt_type (nxt_type[g]),
      .time_q   (cell_time[g]),
      .type_q   (cell_type[g])
    );
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_coin_type  = out_coin_type_r;
  assign out_type_count = out_type_count_r;
  assign out_last       = out_last_r;

endmodule

// ----- rtl/ced_checker.sv -----
// Port-level checks for the coin eject delay scheduler.
// Depends on ced_pkg; bound to coin_eject_delay_scheduler_core below.
module ced_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_action,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [1:0]  out_coin_type,
  input logic [31:0] out_type_count,
  input logic        out_last
);
  import ced_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_coin_type) && $stable(out_type_count) && $stable(out_last))
    else $error("stalled result changed");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

  // A detection request answers next cycle with one final queued or dropped result
  a_detect_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action |=>
      out_valid && out_last && (out_kind == KIND_QUEUED || out_kind == KIND_FULL))
    else $error("detection result missing or malformed");

  // A non-final result means a tick walk is still running
  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("new request taken during a tick walk");

  // A quiet tick reports nothing else
  a_tick_plain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_TICK |->
      out_last && out_coin_type == COIN_JIAO && out_type_count == '0)
    else $error("malformed quiet tick result");

endmodule

bind coin_eject_delay_scheduler_core ced_checker u_ced_checker (.*);
